@@ rtl/core/goertzel_bin_magnitude_top_defines.svh @@
// Assertion macros for the Goertzel bin magnitude block
`ifndef GOERTZEL_BIN_MAGNITUDE_TOP_DEFINES_SVH
`define GOERTZEL_BIN_MAGNITUDE_TOP_DEFINES_SVH

`ifndef SYNTH

// expression must hold at every clock edge out of reset
`define GBM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GBM_ASSERT(label, expr, msg)
`define GBM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/gbm_pkg.sv @@
// Shared types, constants and helpers for the Goertzel bin magnitude block
package gbm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 48;
    localparam int COS_W       = 18;
    localparam int SIN_W       = 17;
    localparam int SCALE_W     = 24;
    localparam int AMP_W       = 16;
    localparam int DATA_W      = 32;
    localparam int CFG_ADDR_W  = 4;

    localparam int REC_SHIFT   = 15;
    localparam int FIN_SHIFT   = 16;
    localparam int SCALE_SHIFT = 23;

    // accumulator split into two halves for the narrow multipliers
    localparam int HALF    = ACC_W / 2;
    localparam int HI_W    = ACC_W - HALF;
    localparam int MB_W    = HALF + 1;
    localparam int MP_W    = COS_W + MB_W;
    localparam int PROD_W  = COS_W + ACC_W;
    localparam int WIDE_W  = PROD_W + 1;

    localparam int UOP_W   = (HI_W > SCALE_W) ? HI_W : SCALE_W;
    localparam int UP_W    = 2 * UOP_W;
    localparam int SUM_W   = 2 * ACC_W;
    localparam int SH_W    = $clog2(SUM_W);
    localparam int REM_W   = ACC_W + 2;
    localparam int CNT_W   = $clog2(ACC_W);
    localparam int SC_W    = ACC_W + SCALE_W;
    localparam int SQ_STEPS = 6;
    localparam int STEP_W  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_beat_t;

    typedef struct packed {
        logic [AMP_W-1:0] amplitude;
        logic             saturated;
    } out_beat_t;

    typedef struct packed {
        logic signed [COS_W-1:0] cosine_term;
        logic [SIN_W-1:0]        sine_term;
        logic [SCALE_W-1:0]      amplitude_scale;
        logic                    bin_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        cosine_term:     COS_W'(65536),
        sine_term:       SIN_W'(0),
        amplitude_scale: SCALE_W'(4096),
        bin_enable:      1'b1
    };

    // accumulator pair handed from front to back at the end of a block
    typedef struct packed {
        logic signed [ACC_W-1:0] recent;
        logic signed [ACC_W-1:0] older;
        logic                    ovf;
    } snap_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    sat;
    } clip_t;

    typedef enum logic [1:0] {
        CFG_COS    = 2'd0,
        CFG_SIN    = 2'd1,
        CFG_SCALE  = 2'd2,
        CFG_ENABLE = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MLO,
        F_MHI,
        F_SUM,
        F_UPD
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CMUL_LO,
        B_CMUL_HI,
        B_SMUL_LO,
        B_SMUL_HI,
        B_REIM,
        B_IMAG,
        B_ABS,
        B_SQUARE,
        B_ROOT,
        B_SC_LO,
        B_SC_HI,
        B_SC_SUM,
        B_DONE
    } back_state_t;

    // saturate a wide signed value to the accumulator range
    function automatic clip_t clip_acc(input logic signed [WIDE_W-1:0] v);
        clip_t r;
        logic [WIDE_W-ACC_W:0] upper;
        upper = v[WIDE_W-1:ACC_W-1];
        if ((&upper) || !(|upper))
        begin
            r.value = v[ACC_W-1:0];
            r.sat   = 1'b0;
        end
        else
        begin
            r.value = v[WIDE_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            r.sat   = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/gbm_queue.sv @@
// Two-entry block queue between the recurrence front and the magnitude back
module gbm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gbm_pkg::snap_t     push_data,
    input  logic               pop,
    output gbm_pkg::snap_t     pop_data,
    output gbm_pkg::q_status_t status
);
    import gbm_pkg::*;

    snap_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/gbm_front.sv @@
// Front: takes sample beats and runs the Goertzel recurrence, queues finished blocks
module gbm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbm_pkg::in_beat_t in_data,
    input  gbm_pkg::cfg_t     cfg,
    input  logic              q_full,
    output logic              push,
    output gbm_pkg::snap_t    push_data
);
    import gbm_pkg::*;

    front_state_t              state_reg, state_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                      last_reg, last_next;
    logic signed [ACC_W-1:0]   recent_reg, recent_next;
    logic signed [ACC_W-1:0]   older_reg, older_next;
    logic                      ovf_reg, ovf_next;
    logic signed [MP_W-1:0]    plo_reg, plo_next;
    logic signed [MP_W-1:0]    phi_reg, phi_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [MP_W-1:0]    mul_p;
    logic signed [WIDE_W-1:0]  acc;
    clip_t                     upd;
    logic                      accept;

    assign in_ready = (state_reg == F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_MLO;
            F_MLO:   state_next = F_MHI;
            F_MHI:   state_next = F_SUM;
            F_SUM:   state_next = F_UPD;
            F_UPD:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // cos * s_recent in two halves through one multiplier
    always_comb
    begin
        if (state_reg == F_MHI)
        begin
            mul_b = MB_W'($signed(recent_reg[ACC_W-1:HALF]));
        end
        else
        begin
            mul_b = $signed({1'b0, recent_reg[HALF-1:0]});
        end
        mul_p = cfg.cosine_term * mul_b;
        acc   = WIDE_W'(x_reg) + (WIDE_W'(prod_reg) >>> REC_SHIFT) - WIDE_W'(older_reg);
        upd   = clip_acc(acc);
    end

    // datapath
    always_comb
    begin
        x_next      = x_reg;
        last_next   = last_reg;
        recent_next = recent_reg;
        older_next  = older_reg;
        ovf_next    = ovf_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        prod_next   = prod_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    x_next    = in_data.sample;
                    last_next = in_data.last_sample;
                end
            end
            F_MLO: plo_next = mul_p;
            F_MHI: phi_next = mul_p;
            F_SUM: prod_next = (PROD_W'(phi_reg) <<< HALF) + PROD_W'(plo_reg);
            F_UPD:
            begin
                if (last_reg)
                begin
                    recent_next = '0;
                    older_next  = '0;
                    ovf_next    = 1'b0;
                end
                else
                begin
                    recent_next = upd.value;
                    older_next  = recent_reg;
                    ovf_next    = ovf_reg | upd.sat;
                end
            end
            default: ;
        endcase
    end

    assign push             = (state_reg == F_UPD) && last_reg;
    assign push_data.recent = upd.value;
    assign push_data.older  = recent_reg;
    assign push_data.ovf    = ovf_reg | upd.sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            recent_reg <= '0;
            older_reg  <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            recent_reg <= recent_next;
            older_reg  <= older_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        last_reg <= last_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        prod_reg <= prod_next;
    end

endmodule

@@ rtl/core/gbm_back.sv @@
// Back: real/imag terms, sum of squares, bit-serial square root, scaling, result register
module gbm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gbm_pkg::cfg_t      cfg,
    input  logic               q_empty,
    output logic               pop,
    input  gbm_pkg::snap_t     pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gbm_pkg::out_beat_t out_data
);
    import gbm_pkg::*;

    back_state_t              state_reg, state_next;
    logic signed [ACC_W-1:0]  r_reg, r_next;
    logic signed [ACC_W-1:0]  o_reg, o_next;
    logic                     sat_reg, sat_next;
    logic signed [MP_W-1:0]   plo_reg, plo_next;
    logic signed [MP_W-1:0]   phi_reg, phi_next;
    logic signed [PROD_W-1:0] prodc_reg, prodc_next;
    logic signed [PROD_W-1:0] prods_reg, prods_next;
    logic signed [ACC_W-1:0]  re_reg, re_next;
    logic signed [ACC_W-1:0]  im_reg, im_next;
    logic [ACC_W-1:0]         re_abs_reg, re_abs_next;
    logic [ACC_W-1:0]         im_abs_reg, im_abs_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [UP_W-1:0]          up_reg, up_next;
    logic [SH_W-1:0]          sh_reg, sh_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ACC_W-1:0]         root_reg, root_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SC_W-1:0]          sc_reg, sc_next;
    logic                     out_valid_reg, out_valid_next;
    out_beat_t                out_data_reg, out_data_next;

    logic signed [COS_W-1:0]  mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   mul_p;
    logic signed [PROD_W-1:0] merged;
    clip_t                    re_clip, im_clip;
    logic [UOP_W-1:0]         ua, ub;
    logic [SH_W-1:0]          sq_sh;
    logic [UP_W-1:0]          up;
    logic [REM_W-1:0]         rem_sh, trial;
    logic                     root_bit;
    logic                     amp_over;
    logic [AMP_W-1:0]         amp_val;
    logic                     out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == B_IDLE) && !q_empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:    if (!q_empty) state_next = B_CMUL_LO;
            B_CMUL_LO: state_next = B_CMUL_HI;
            B_CMUL_HI: state_next = B_SMUL_LO;
            B_SMUL_LO: state_next = B_SMUL_HI;
            B_SMUL_HI: state_next = B_REIM;
            B_REIM:    state_next = B_IMAG;
            B_IMAG:    state_next = B_ABS;
            B_ABS:     state_next = B_SQUARE;
            B_SQUARE:  if (step_reg == STEP_W'(SQ_STEPS)) state_next = B_ROOT;
            B_ROOT:    if (cnt_reg == CNT_W'(ACC_W - 1)) state_next = B_SC_LO;
            B_SC_LO:   state_next = B_SC_HI;
            B_SC_HI:   state_next = B_SC_SUM;
            B_SC_SUM:  state_next = B_DONE;
            B_DONE:    if (out_free) state_next = B_IDLE;
            default:   state_next = B_IDLE;
        endcase
    end

    // shared signed multiplier: cos or sin times one half of s_older
    always_comb
    begin
        if ((state_reg == B_SMUL_LO) || (state_reg == B_SMUL_HI))
        begin
            mul_a = $signed(COS_W'(cfg.sine_term));
        end
        else
        begin
            mul_a = cfg.cosine_term;
        end
        if ((state_reg == B_CMUL_HI) || (state_reg == B_SMUL_HI))
        begin
            mul_b = MB_W'($signed(o_reg[ACC_W-1:HALF]));
        end
        else
        begin
            mul_b = $signed({1'b0, o_reg[HALF-1:0]});
        end
        mul_p   = mul_a * mul_b;
        merged  = (PROD_W'(phi_reg) <<< HALF) + PROD_W'(plo_reg);
        re_clip = clip_acc(WIDE_W'(r_reg) - (WIDE_W'(prodc_reg) >>> FIN_SHIFT));
        im_clip = clip_acc(WIDE_W'(prods_reg) >>> FIN_SHIFT);
    end

    // shared unsigned multiplier: square partial products, then magnitude times scale
    always_comb
    begin
        ua    = '0;
        ub    = '0;
        sq_sh = '0;
        if (state_reg == B_SC_LO)
        begin
            ua = UOP_W'(root_reg[HALF-1:0]);
            ub = UOP_W'(cfg.amplitude_scale);
        end
        else if (state_reg == B_SC_HI)
        begin
            ua = UOP_W'(root_reg[ACC_W-1:HALF]);
            ub = UOP_W'(cfg.amplitude_scale);
        end
        else
        begin
            case (step_reg)
                3'd0:
                begin
                    ua = UOP_W'(re_abs_reg[HALF-1:0]);
                    ub = UOP_W'(re_abs_reg[HALF-1:0]);
                end
                3'd1:
                begin
                    ua    = UOP_W'(re_abs_reg[HALF-1:0]);
                    ub    = UOP_W'(re_abs_reg[ACC_W-1:HALF]);
                    sq_sh = SH_W'(HALF + 1);
                end
                3'd2:
                begin
                    ua    = UOP_W'(re_abs_reg[ACC_W-1:HALF]);
                    ub    = UOP_W'(re_abs_reg[ACC_W-1:HALF]);
                    sq_sh = SH_W'(2 * HALF);
                end
                3'd3:
                begin
                    ua = UOP_W'(im_abs_reg[HALF-1:0]);
                    ub = UOP_W'(im_abs_reg[HALF-1:0]);
                end
                3'd4:
                begin
                    ua    = UOP_W'(im_abs_reg[HALF-1:0]);
                    ub    = UOP_W'(im_abs_reg[ACC_W-1:HALF]);
                    sq_sh = SH_W'(HALF + 1);
                end
                3'd5:
                begin
                    ua    = UOP_W'(im_abs_reg[ACC_W-1:HALF]);
                    ub    = UOP_W'(im_abs_reg[ACC_W-1:HALF]);
                    sq_sh = SH_W'(2 * HALF);
                end
                default: ;
            endcase
        end
        up = ua * ub;
    end

    // one root bit per cycle; sum_reg doubles as the radicand shift register
    always_comb
    begin
        rem_sh   = {rem_reg[REM_W-3:0], sum_reg[SUM_W-1:SUM_W-2]};
        trial    = {root_reg, 2'b01};
        root_bit = (rem_sh >= trial);
        amp_over = |sc_reg[SC_W-1:SCALE_SHIFT+AMP_W];
        amp_val  = amp_over ? {AMP_W{1'b1}} : sc_reg[SCALE_SHIFT+AMP_W-1:SCALE_SHIFT];
    end

    // datapath
    always_comb
    begin
        r_next         = r_reg;
        o_next         = o_reg;
        sat_next       = sat_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        prodc_next     = prodc_reg;
        prods_next     = prods_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        re_abs_next    = re_abs_reg;
        im_abs_next    = im_abs_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        up_next        = up_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        cnt_next       = cnt_reg;
        sc_next        = sc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    r_next   = pop_data.recent;
                    o_next   = pop_data.older;
                    sat_next = pop_data.ovf;
                end
            end
            B_CMUL_LO: plo_next = mul_p;
            B_CMUL_HI: phi_next = mul_p;
            B_SMUL_LO:
            begin
                prodc_next = merged;
                plo_next   = mul_p;
            end
            B_SMUL_HI: phi_next = mul_p;
            B_REIM:
            begin
                prods_next = merged;
                re_next    = re_clip.value;
                sat_next   = sat_reg | re_clip.sat;
            end
            B_IMAG:
            begin
                im_next  = im_clip.value;
                sat_next = sat_reg | im_clip.sat;
            end
            B_ABS:
            begin
                re_abs_next = re_reg[ACC_W-1] ? (~re_reg + 1'b1) : re_reg;
                im_abs_next = im_reg[ACC_W-1] ? (~im_reg + 1'b1) : im_reg;
                step_next   = '0;
                sum_next    = '0;
                rem_next    = '0;
                root_next   = '0;
                cnt_next    = '0;
            end
            B_SQUARE:
            begin
                // product of the previous step is added while the next one forms
                if (step_reg != '0)
                begin
                    sum_next = sum_reg + (SUM_W'(up_reg) << sh_reg);
                end
                if (step_reg < STEP_W'(SQ_STEPS))
                begin
                    up_next = up;
                    sh_next = sq_sh;
                end
                step_next = step_reg + 1'b1;
            end
            B_ROOT:
            begin
                sum_next = sum_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (root_bit)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ACC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ACC_W-2:0], 1'b0};
                end
            end
            B_SC_LO: up_next = up;
            B_SC_HI:
            begin
                sc_next = SC_W'(up_reg);
                up_next = up;
            end
            B_SC_SUM: sc_next = sc_reg + (SC_W'(up_reg) << HALF);
            B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.amplitude = cfg.bin_enable ? amp_val : '0;
                    out_data_next.saturated = sat_reg | (amp_over & cfg.bin_enable);
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        o_reg        <= o_next;
        sat_reg      <= sat_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        prodc_reg    <= prodc_next;
        prods_reg    <= prods_next;
        re_reg       <= re_next;
        im_reg       <= im_next;
        re_abs_reg   <= re_abs_next;
        im_abs_reg   <= im_abs_next;
        step_reg     <= step_next;
        sum_reg      <= sum_next;
        up_reg       <= up_next;
        sh_reg       <= sh_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        cnt_reg      <= cnt_next;
        sc_reg       <= sc_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/core/goertzel_bin_magnitude_top.sv @@
// Top level of the single-bin Goertzel magnitude detector with its register port
//
//  channel  | direction | handshake           | beat
//  ---------+-----------+---------------------+-------------------------------
//  in       | in        | in_valid / in_ready | in_data: sample, last_sample
//  out      | out       | out_valid/out_ready | out_data: amplitude, saturated
//  cfg      | in        | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// Sample beats: after taking a sample the front runs its recurrence steps (low and high
// halves of the split 18x25 multiply, merge, update with clip) before it takes the next;
// in_ready drops while the block queue is full. Block result: after the block leaves the
// two-entry queue, the back forms the terms, sums squares, takes the bit-serial square root and scales.
// Reset clears the accumulators, queue and result valid and loads register defaults.
// A stalled out beat holds the back; the front keeps taking samples until the queue fills.
module goertzel_bin_magnitude_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  gbm_pkg::in_beat_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output gbm_pkg::out_beat_t             out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gbm_pkg::DATA_W-1:0]     pwdata,
    output logic [gbm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import gbm_pkg::*;

`include "goertzel_bin_magnitude_top_defines.svh"

    cfg_t       cfg_reg, cfg_next;
    cfg_index_t cfg_idx;
    logic       cfg_wr;
    logic       q_push, q_pop;
    snap_t      q_push_data, q_pop_data;
    q_status_t  q_stat;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_COS:    cfg_next.cosine_term     = pwdata[COS_W-1:0];
                CFG_SIN:    cfg_next.sine_term       = pwdata[SIN_W-1:0];
                CFG_SCALE:  cfg_next.amplitude_scale = pwdata[SCALE_W-1:0];
                CFG_ENABLE: cfg_next.bin_enable      = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_COS:    prdata = {{(DATA_W-COS_W){1'b0}}, cfg_reg.cosine_term};
            CFG_SIN:    prdata = {{(DATA_W-SIN_W){1'b0}}, cfg_reg.sine_term};
            CFG_SCALE:  prdata = {{(DATA_W-SCALE_W){1'b0}}, cfg_reg.amplitude_scale};
            CFG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.bin_enable};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .q_full    (q_stat.full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    gbm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_stat)
    );

    gbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_stat.empty),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `GBM_ASSERT(a_push_room, !(q_push && q_stat.full), "block pushed into a full queue")
    `GBM_ASSERT(a_pop_data, !(q_pop && q_stat.empty), "block popped from an empty queue")
    `GBM_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready, "sample taken while busy")
    `GBM_ASSERT(a_disabled_zero, !out_valid || cfg_reg.bin_enable || ~|out_data.amplitude, "amp not zero")

endmodule

@@ sim/tb.sv @@
// Self-checking bench for the single-bin Goertzel magnitude top level
`timescale 1ns / 1ps

module tb;
    import gbm_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 150;
    localparam int HOLD_CYCLES = 700;
    localparam int PHASE_ITEMS = 60;

    localparam logic signed [127:0] ACC_MAX = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] ACC_MIN = -ACC_MAX - 128'sd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    goertzel_bin_magnitude_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #CLK_HALF clk = ~clk;

    // predictor copy of the registers and accumulators
    logic signed [COS_W-1:0] cos_q   = CFG_RESET.cosine_term;
    logic [SIN_W-1:0]        sin_q   = CFG_RESET.sine_term;
    logic [SCALE_W-1:0]      scale_q = CFG_RESET.amplitude_scale;
    logic                    enable_q = CFG_RESET.bin_enable;
    logic signed [ACC_W-1:0] acc_recent = '0;
    logic signed [ACC_W-1:0] acc_older = '0;
    logic                    ovf_seen = 1'b0;

    in_beat_t  pending_beats[$];
    out_beat_t amp_expected[$];

    int mismatches = 0;
    int cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int rx_tick = 0;
    int rx_mode = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [127:0] v,
                                                        output logic hit);
        hit = 1'b0;
        if (v > ACC_MAX)
        begin
            hit = 1'b1;
            return ACC_MAX[ACC_W-1:0];
        end
        if (v < ACC_MIN)
        begin
            hit = 1'b1;
            return ACC_MIN[ACC_W-1:0];
        end
        return v[ACC_W-1:0];
    endfunction

    // run one sample through the recurrence; a last sample yields the amplitude
    task automatic goertzel_step(input in_beat_t b);
        logic signed [127:0] x, rec_w, old_w, cos_w, sin_w, acc, re_w, im_w;
        logic signed [ACC_W-1:0] s, re, im;
        logic [127:0] sum, sq, root_w, scaled, amp_w;
        logic [63:0] root, c;
        logic hit, sat;
        out_beat_t r;
        int k;
        x = b.sample;
        rec_w = acc_recent;
        old_w = acc_older;
        cos_w = cos_q;
        sin_w = sin_q;
        acc = x + ((cos_w * rec_w) >>> REC_SHIFT) - old_w;
        s = sat_acc(acc, hit);
        acc_older = acc_recent;
        acc_recent = s;
        if (hit)
            ovf_seen = 1'b1;
        if (b.last_sample)
        begin
            sat = ovf_seen;
            rec_w = acc_recent;
            old_w = acc_older;
            re = sat_acc(rec_w - ((old_w * cos_w) >>> FIN_SHIFT), hit);
            sat = sat | hit;
            im = sat_acc((old_w * sin_w) >>> FIN_SHIFT, hit);
            sat = sat | hit;
            re_w = re;
            im_w = im;
            if (re_w < 0)
                re_w = -re_w;
            if (im_w < 0)
                im_w = -im_w;
            sum = re_w * re_w + im_w * im_w;
            root = '0;
            for (k = 63; k >= 0; k--)
            begin
                c = root | (64'd1 << k);
                sq = {64'd0, c} * {64'd0, c};
                if (sq <= sum)
                    root = c;
            end
            root_w = {64'd0, root};
            scaled = root_w * {104'd0, scale_q};
            amp_w = scaled >> SCALE_SHIFT;
            if (amp_w > 128'd65535)
            begin
                r.amplitude = 16'hFFFF;
                if (enable_q)
                    sat = 1'b1;
            end
            else
                r.amplitude = amp_w[AMP_W-1:0];
            if (!enable_q)
                r.amplitude = '0;
            r.saturated = sat;
            amp_expected.push_back(r);
            acc_recent = '0;
            acc_older = '0;
            ovf_seen = 1'b0;
        end
    endtask

    task automatic note_fail(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // sender: bursts of beats with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                goertzel_step(in_data);
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    in_data <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (rx_tick == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    rx_tick = $urandom_range(50, 300);
                end
                else
                    rx_tick--;
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // monitor: compare each result beat with the oldest expected one
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (amp_expected.size() == 0)
                note_fail($sformatf("unexpected result amp=%0d sat=%0d",
                                    out_data.amplitude, out_data.saturated));
            else
            begin
                want = amp_expected.pop_front();
                if (out_data.amplitude !== want.amplitude ||
                    out_data.saturated !== want.saturated)
                    note_fail($sformatf("mismatch: expected amp=%0d sat=%0d, got amp=%0d sat=%0d",
                                        want.amplitude, want.saturated,
                                        out_data.amplitude, out_data.saturated));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** goertzel_bin_magnitude_top: FAILED **");
            $finish;
        end
    end

    task automatic push_beat(input logic signed [SAMPLE_W-1:0] s, input logic last);
        in_beat_t b;
        b.sample = s;
        b.last_sample = last;
        pending_beats.push_back(b);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style,
                                                               input logic [15:0] level);
        case (style)
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return 16'($urandom_range(0, 512) - 256);
            default: return level;
        endcase
    endfunction

    // wait for every beat to go in and every result to come out, then let the front drain
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (amp_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] mask, v;
        case (idx)
            CFG_COS:   mask = 32'h0003_FFFF;
            CFG_SIN:   mask = 32'h0001_FFFF;
            CFG_SCALE: mask = 32'h00FF_FFFF;
            default:   mask = 32'h0000_0001;
        endcase
        // unused upper bits sometimes carry junk
        v = (val & mask) | ($urandom_range(0, 1) ? ($urandom & ~mask) : 32'd0);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            CFG_COS:   cos_q = v[COS_W-1:0];
            CFG_SIN:   sin_q = v[SIN_W-1:0];
            CFG_SCALE: scale_q = v[SCALE_W-1:0];
            default:   enable_q = v[0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input int cv, input int sv, input int scv, input int en);
        wait_idle();
        cfg_write(CFG_COS, cv);
        cfg_write(CFG_SIN, sv);
        cfg_write(CFG_SCALE, scv);
        cfg_write(CFG_ENABLE, en);
    endtask

    task automatic random_blocks(input int count);
        int n, len, style, i;
        logic [15:0] level;
        n = 0;
        while (n < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 32) : $urandom_range(1, 12);
            style = $urandom_range(0, 3);
            level = 16'($urandom);
            // now and then a stray run of samples with no end marker
            for (i = 0; i < len; i++)
                push_beat(pick_sample(style, level),
                          (i == len - 1) && ($urandom_range(0, 7) != 0));
            n += len;
        end
    endtask

    initial
    begin
        int i, ph, cv, sv, scv, en;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes of the sample, a one-sample block
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sh0000, 1'b1);
        push_beat(16'sh8000, 1'b1);

        // Nyquist bin
        set_config(-65536, 0, 8388608, 1);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sh7FFF, 1'b1);

        // feedback beyond range: accumulators clip, amplitude clips
        set_config(-131072, 131071, 16777215, 1);
        for (i = 0; i < 20; i++)
            push_beat(16'sh7FFF, i == 19);

        // disabled bin still runs and clears
        set_config(131071, 65536, 16777215, 0);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sh7FFF, 1'b1);

        // long receiver hold-off while short blocks keep coming
        set_config(65536, 0, 4096, 1);
        @(posedge clk);
        hold_go <= 1'b1;
        for (i = 0; i < 40; i++)
            push_beat(16'($urandom), (i % 2 == 1) || ($urandom_range(0, 1) == 0));

        for (ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 4))
                0: cv = -131072;
                1: cv = 131071;
                2: cv = ($urandom_range(0, 1) == 0) ? -65536 : 65536;
                default: cv = int'($urandom_range(0, 131072)) - 65536;
            endcase
            case ($urandom_range(0, 5))
                0: sv = 0;
                1: sv = 65536;
                2: sv = 131071;
                default: sv = $urandom_range(0, 65536);
            endcase
            case ($urandom_range(0, 4))
                0: scv = 0;
                1: scv = 16777215;
                2: scv = 8388608;
                default: scv = $urandom_range(0, 16777215);
            endcase
            en = ($urandom_range(0, 4) != 0) ? 1 : 0;
            set_config(cv, sv, scv, en);
            random_blocks(PHASE_ITEMS);
        end

        while (pending_beats.size() != 0 || in_valid)
            @(posedge clk);
        while (amp_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && amp_expected.size() == 0)
            $display("** goertzel_bin_magnitude_top: PASSED **");
        else
            $display("** goertzel_bin_magnitude_top: FAILED **");
        $finish;
    end

endmodule
